/* hdl/rmf_pkg.sv */
// ----------------------------------------------------------------------------
// rmf_pkg: shared definitions for the row median filter
// Register indexes and fixed widths of the configuration port.
// ----------------------------------------------------------------------------
package rmf_pkg;

   // Configuration register indexes (word index on the register port).
   localparam logic REG_WINDOW_WIDTH = 1'b0;
   localparam logic REG_EDGE_MODE    = 1'b1;

   // Fixed field widths.
   localparam int WINDOW_W = 4;
   localparam int ADDR_W   = 3;
   localparam int DATA_W   = 32;

   // Window width after reset.
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 4'd3;

endpackage

/* hdl/row_median_filter.sv */
// ----------------------------------------------------------------------------
// row_median_filter: streaming running median over a row of samples
// Sample taps feed a chain of insertion sorting cells; the median is read
// from cell h of the sorted chain, the middle of the 2*h+1 values fed.
// ----------------------------------------------------------------------------
//   channel   prefix  direction  content
//   request   req_    in         sample, row_end
//   response  rsp_    out        median, run_last, row_done, short_row
//   register  csr_    in/out     window_width (0x0), edge_mode (0x4)
//
// Each result clears the chain, feeds it the 2*h+1 window values, lets it settle
// and then emits it; the sorting chain takes one value a cycle while feeding.
// A sample with no result leaves the filter idle; row_end flushes up to h+1.
// Reset clears control state; the sample taps are not cleared.
// A stalled response holds the filter after the next result is computed;
// a new request is taken while the last result still waits.
module row_median_filter
   import rmf_pkg::*;
#(
   parameter int MAX_WINDOW  = 15,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_row_end,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_median,
   output logic                          rsp_run_last,
   output logic                          rsp_row_done,
   output logic                          rsp_short_row,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [ADDR_W-1:0]             csr_paddr,
   input  logic [DATA_W-1:0]             csr_pwdata,
   output logic [DATA_W-1:0]             csr_prdata,
   output logic                          csr_pready
);

   localparam int HALF_MAX = (MAX_WINDOW - 1) / 2;
   localparam int IDX_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
   localparam int AGE_W    = IDX_W + 3;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CLEAR, ST_FEED, ST_SETTLE, ST_EMIT
   } state_type;

   // Configuration registers.
   logic [WINDOW_W-1:0] window_width_ff;
   logic                edge_mode_ff;
   logic                csr_write;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_width_ff <= WINDOW_RESET;
         edge_mode_ff    <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_WINDOW_WIDTH: window_width_ff <= csr_pwdata[WINDOW_W-1:0];
            REG_EDGE_MODE:    edge_mode_ff    <= csr_pwdata[0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[2])
         REG_WINDOW_WIDTH: csr_prdata = DATA_W'(window_width_ff);
         REG_EDGE_MODE:    csr_prdata = DATA_W'(edge_mode_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // Half window from the register, capped by the tap count.
   logic [WINDOW_W-2:0] half_raw;
   logic [IDX_W-1:0]    half_now;

   always_comb begin
      half_raw = (window_width_ff == '0) ? '0
                                         : (WINDOW_W-1)'((window_width_ff - 1'b1) >> 1);
      if (int'(half_raw) > HALF_MAX) begin
         half_now = IDX_W'(HALF_MAX);
      end else begin
         half_now = IDX_W'(half_raw);
      end
   end

   // Control registers.
   state_type                     state_ff;
   logic [CNT_W-1:0]              row_count_ff;
   logic [IDX_W-1:0]              half_ff, dist_ff, pos_ff, feed_ff;
   logic [CNT_W-1:0]              settle_ff;
   logic                          last_ff, short_ff, mirror_ff;
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] median_ff;
   logic                          run_last_ff, row_done_ff, short_row_ff;
   logic signed [SAMPLE_BITS-1:0] taps_ff [MAX_WINDOW];

   logic                          req_take;
   logic [CNT_W-1:0]              count_next;
   logic [IDX_W-1:0]              pos_next;
   logic                          out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      count_next = (int'(row_count_ff) < MAX_WINDOW) ? CNT_W'(row_count_ff + 1'b1)
                                                     : row_count_ff;
      pos_next   = IDX_W'(count_next - 1'b1);
   end

   // Sample taps: shift line, newest at index zero.
   always_ff @(posedge clock) begin
      if (req_take) begin
         taps_ff[0] <= req_sample;
         for (int k = 1; k < MAX_WINDOW; k++) begin
            taps_ff[k] <= taps_ff[k-1];
         end
      end
   end

   // Window fetch with zero or mirror handling at the row edges.
   logic signed [AGE_W-1:0]       age_raw, age_fix, pos_ext;
   logic                          age_ok;
   logic signed [SAMPLE_BITS-1:0] feed_value;

   always_comb begin
      pos_ext = $signed(AGE_W'(pos_ff));
      age_raw = $signed(AGE_W'(dist_ff)) + $signed(AGE_W'(half_ff))
                - $signed(AGE_W'(feed_ff));
      age_fix = age_raw;
      if (mirror_ff) begin
         if (age_raw < 0) begin
            age_fix = -age_raw;
         end else if (age_raw > pos_ext) begin
            age_fix = (pos_ext <<< 1) - age_raw;
         end
      end
      age_ok     = (age_fix >= 0) && (age_fix <= pos_ext);
      feed_value = age_ok ? taps_ff[age_fix[IDX_W-1:0]] : '0;
   end

   // Sorting chain.
   logic                          chain_clear, chain_feed;
   logic                          link_valid [MAX_WINDOW+1];
   logic signed [SAMPLE_BITS-1:0] link_value [MAX_WINDOW+1];
   logic signed [SAMPLE_BITS-1:0] cell_value [MAX_WINDOW];

   assign chain_clear   = (state_ff == ST_CLEAR);
   assign chain_feed    = (state_ff == ST_FEED);
   assign link_valid[0] = chain_feed;
   assign link_value[0] = feed_value;

   for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
      rmf_sort_cell #(
         .SAMPLE_BITS(SAMPLE_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .clear     (chain_clear),
         .in_valid  (link_valid[g]),
         .in_value  (link_value[g]),
         .out_valid (link_valid[g+1]),
         .out_value (link_value[g+1]),
         .held_value(cell_value[g])
      );
   end

   // Sequencer and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // The emit state reloads the response register itself.
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  half_ff   <= half_now;
                  mirror_ff <= edge_mode_ff;
                  pos_ff    <= pos_next;
                  last_ff   <= req_row_end;
                  short_ff  <= edge_mode_ff && (int'(count_next) <= int'(half_now));
                  if (req_row_end) begin
                     row_count_ff <= '0;
                     dist_ff      <= (pos_next < half_now) ? pos_next : half_now;
                     state_ff     <= ST_CLEAR;
                  end else begin
                     row_count_ff <= count_next;
                     dist_ff      <= half_now;
                     if (pos_next >= half_now) begin
                        state_ff <= ST_CLEAR;
                     end
                  end
               end
            end
            ST_CLEAR: begin
               feed_ff  <= '0;
               state_ff <= ST_FEED;
            end
            ST_FEED: begin
               feed_ff <= IDX_W'(feed_ff + 1'b1);
               if (feed_ff == IDX_W'({half_ff, 1'b0})) begin
                  settle_ff <= '0;
                  state_ff  <= ST_SETTLE;
               end
            end
            ST_SETTLE: begin
               settle_ff <= CNT_W'(settle_ff + 1'b1);
               if (int'(settle_ff) == MAX_WINDOW - 1) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  median_ff    <= cell_value[half_ff];
                  run_last_ff  <= !last_ff || (dist_ff == '0);
                  row_done_ff  <= last_ff && (dist_ff == '0);
                  short_row_ff <= last_ff && short_ff;
                  if (last_ff && (dist_ff != '0)) begin
                     dist_ff  <= IDX_W'(dist_ff - 1'b1);
                     state_ff <= ST_CLEAR;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_median    = median_ff;
   assign rsp_run_last  = run_last_ff;
   assign rsp_row_done  = row_done_ff;
   assign rsp_short_row = short_row_ff;

endmodule

/* hdl/rmf_sort_cell.sv */
// ----------------------------------------------------------------------------
// rmf_sort_cell: one cell of the insertion sorting chain
// Keeps the smallest value it has seen and hands the larger one to the right.
// ----------------------------------------------------------------------------
module rmf_sort_cell
   import rmf_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  logic                          in_valid,
   input  logic signed [SAMPLE_BITS-1:0] in_value,
   output logic                          out_valid,
   output logic signed [SAMPLE_BITS-1:0] out_value,
   output logic signed [SAMPLE_BITS-1:0] held_value
);

   logic                          full_ff, full_in;
   logic signed [SAMPLE_BITS-1:0] value_ff, value_in;
   logic                          pass_ff, pass_in;
   logic signed [SAMPLE_BITS-1:0] pass_value_ff, pass_value_in;

   // Compare the arriving value with the held one.
   always_comb begin
      full_in       = full_ff;
      value_in      = value_ff;
      pass_in       = 1'b0;
      pass_value_in = pass_value_ff;
      if (clear) begin
         full_in = 1'b0;
      end else if (in_valid) begin
         if (!full_ff) begin
            full_in  = 1'b1;
            value_in = in_value;
         end else if (in_value < value_ff) begin
            value_in      = in_value;
            pass_in       = 1'b1;
            pass_value_in = value_ff;
         end else begin
            pass_in       = 1'b1;
            pass_value_in = in_value;
         end
      end
   end

   // Control bits are reset; values are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         pass_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
         pass_ff <= pass_in;
      end
      value_ff      <= value_in;
      pass_value_ff <= pass_value_in;
   end

   assign out_valid  = pass_ff;
   assign out_value  = pass_value_ff;
   assign held_value = value_ff;

endmodule

/* verif/row_median_filter_tb.sv */
// ----------------------------------------------------------------------------
// row_median_filter_tb: self-checking testbench for the row median filter
// Rows of signed samples are streamed through the request channel under
// random idling on both sides. A behavioral filter predicts every response
// transaction, which is compared field by field in arrival order. Window
// width and edge mode are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module row_median_filter_tb
   import rmf_pkg::*;
;

   localparam int MAXW = 15;
   localparam int SBITS = 16;
   localparam int FLUSH_WAIT = 400;

   typedef struct {
      logic signed [SBITS-1:0] sample;
      logic                    row_end;
   } sample_type;

   typedef struct {
      logic signed [SBITS-1:0] median;
      logic                    run_last;
      logic                    row_done;
      logic                    short_row;
   } median_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic signed [SBITS-1:0] req_sample = '0;
   logic                    req_row_end = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [SBITS-1:0] rsp_median;
   logic                    rsp_run_last;
   logic                    rsp_row_done;
   logic                    rsp_short_row;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]       csr_paddr = '0;
   logic [DATA_W-1:0]       csr_pwdata = '0;
   logic [DATA_W-1:0]       csr_prdata;
   logic                    csr_pready;

   row_median_filter #(.MAX_WINDOW(MAXW), .SAMPLE_BITS(SBITS)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_sample(req_sample), .req_row_end(req_row_end),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_median(rsp_median), .rsp_run_last(rsp_run_last),
      .rsp_row_done(rsp_row_done), .rsp_short_row(rsp_short_row),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   // Clock with a period of 12 time units.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow of the filter: sample history, row position and registers.
   logic signed [SBITS-1:0] history [MAXW];
   int unsigned             row_fill = 0;
   logic [WINDOW_W-1:0]     win_reg = WINDOW_RESET;
   logic                    mirror_reg = 1'b0;

   sample_type pending_samples[$];
   median_type expected_medians[$];
   int      errors = 0;
   int      samples_sent = 0;
   int      medians_seen = 0;
   bit      req_idling = 1'b1;
   bit      rsp_idling = 1'b1;

   // Sample at a given age behind the newest one, with edge handling.
   function automatic logic signed [SBITS-1:0] tap_at(int age, int newest);
      if (mirror_reg) begin
         if (age < 0) age = -age;
         else if (age > newest) age = 2 * newest - age;
      end
      if (age < 0 || age > newest || age >= MAXW) return '0;
      return history[age];
   endfunction

   function automatic logic signed [SBITS-1:0] window_median(int d, int h, int newest);
      logic signed [SBITS-1:0] win [MAXW];
      logic signed [SBITS-1:0] v;
      int j;
      for (int i = 0; i < 2 * h + 1; i++) begin
         v = tap_at(d + h - i, newest);
         j = i;
         while (j > 0 && win[j-1] > v) begin
            win[j] = win[j-1];
            j--;
         end
         win[j] = v;
      end
      return win[h];
   endfunction

   // Push the responses that one accepted sample causes.
   function automatic void predict_medians(sample_type s);
      int      h;
      int      pos;
      int      first;
      logic    short_flag;
      median_type m;
      h = (win_reg == 0) ? 0 : (int'(win_reg) - 1) / 2;
      if (h > (MAXW - 1) / 2) h = (MAXW - 1) / 2;
      for (int i = MAXW - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = s.sample;
      if (row_fill < MAXW) row_fill++;
      pos = int'(row_fill) - 1;
      if (!s.row_end) begin
         if (pos >= h) begin
            m.median = window_median(h, h, pos);
            m.run_last = 1'b1;
            m.row_done = 1'b0;
            m.short_row = 1'b0;
            expected_medians.push_back(m);
         end
      end else begin
         short_flag = mirror_reg && (row_fill < h + 1);
         first = (pos < h) ? pos : h;
         for (int d = first; d >= 0; d--) begin
            m.median = window_median(d, h, pos);
            m.run_last = (d == 0);
            m.row_done = (d == 0);
            m.short_row = short_flag;
            expected_medians.push_back(m);
         end
         row_fill = 0;
      end
   endfunction

   function automatic int draw_gap(bit idling);
      return idling ? $urandom_range(0, 15) : 0;
   endfunction

   // Request driver: one sample transaction at a time from the pending queue.
   int req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_gap > 0 || pending_samples.size() == 0) begin
            req_valid <= 1'b0;
            if (req_gap > 0) req_gap--;
         end else begin
            sample_type s;
            s = pending_samples.pop_front();
            req_sample <= s.sample;
            req_row_end <= s.row_end;
            req_valid <= 1'b1;
            req_gap = draw_gap(req_idling);
         end
      end
   end

   // Monitor: predicts on accepted requests, checks accepted responses.
   int rsp_stall = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            sample_type s;
            s.sample = req_sample;
            s.row_end = req_row_end;
            predict_medians(s);
            samples_sent++;
         end
         if (rsp_valid && rsp_ready) begin
            medians_seen++;
            if (expected_medians.size() == 0) begin
               $display("%0t: unexpected response median=%0d", $time, rsp_median);
               errors++;
            end else begin
               median_type m;
               m = expected_medians.pop_front();
               if (rsp_median !== m.median || rsp_run_last !== m.run_last ||
                   rsp_row_done !== m.row_done || rsp_short_row !== m.short_row) begin
                  $display("%0t: mismatch expected %0d/%b/%b/%b actual %0d/%b/%b/%b",
                           $time, m.median, m.run_last, m.row_done, m.short_row,
                           rsp_median, rsp_run_last, rsp_row_done, rsp_short_row);
                  errors++;
               end
            end
            rsp_stall = draw_gap(rsp_idling);
         end else if (rsp_stall > 0) begin
            rsp_stall--;
         end
         rsp_ready <= (rsp_stall == 0);
      end
   end

   // Register write through the setup and access cycles.
   task automatic csr_write(logic idx, logic [DATA_W-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == REG_WINDOW_WIDTH) win_reg = value[WINDOW_W-1:0];
      else mirror_reg = value[0];
   endtask

   // Wait until every sample is taken and every response has come back.
   task automatic drain();
      do @(posedge clock);
      while (pending_samples.size() != 0 || req_valid || expected_medians.size() != 0);
      repeat (FLUSH_WAIT) @(posedge clock);
   endtask

   task automatic add_sample(logic signed [SBITS-1:0] v, logic last);
      sample_type s;
      s.sample = v;
      s.row_end = last;
      pending_samples.push_back(s);
   endtask

   function automatic logic signed [SBITS-1:0] pick_sample();
      case ($urandom_range(0, 5))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return SBITS'(int'($urandom_range(0, 7)) - 4);
         default: return SBITS'($urandom());
      endcase
   endfunction

   initial begin
      int len;
      int budget;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes with the reset window and zero padding.
      add_sample(16'sh7fff, 1'b0);
      add_sample(16'sh8000, 1'b0);
      add_sample(16'sh0000, 1'b0);
      add_sample(16'shffff, 1'b1);
      add_sample(16'sh1234, 1'b1);
      drain();

      // Widest window in mirror mode: a short row, then a longer one.
      csr_write(REG_WINDOW_WIDTH, 15);
      csr_write(REG_EDGE_MODE, 1);
      add_sample(16'sh7fff, 1'b0);
      add_sample(-16'sd5, 1'b0);
      add_sample(16'sh8000, 1'b1);
      for (int i = 0; i < 10; i++) begin
         add_sample(SBITS'(16'sh5555 ^ (i * 16'sh1111)), i == 9);
      end
      drain();

      // Pass through and an even width.
      csr_write(REG_WINDOW_WIDTH, 0);
      add_sample(16'sh8000, 1'b0);
      add_sample(16'sh7fff, 1'b1);
      drain();
      csr_write(REG_WINDOW_WIDTH, 4);
      csr_write(REG_EDGE_MODE, 0);
      add_sample(16'sd9, 1'b0);
      add_sample(-16'sd3, 1'b0);
      add_sample(16'sd7, 1'b0);
      drain();

      // Register change in the middle of a row.
      csr_write(REG_WINDOW_WIDTH, 9);
      add_sample(-16'sd20, 1'b0);
      add_sample(16'sd30, 1'b1);
      drain();

      // Random phases with random settings and idling.
      for (int phase = 0; phase < 10; phase++) begin
         csr_write(REG_WINDOW_WIDTH, (phase == 0) ? 15 : (phase == 1) ? 1 :
                   $urandom_range(0, 15));
         csr_write(REG_EDGE_MODE, $urandom_range(0, 1));
         req_idling = (phase % 3 != 2);
         rsp_idling = (phase % 4 != 3);
         budget = 18;
         while (budget > 0) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 20);
            for (int i = 0; i < len; i++) add_sample(pick_sample(), i == len - 1);
            budget -= len;
         end
         drain();
      end

      if (expected_medians.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, expected_medians.size());
         errors++;
      end
      $display("Streamed %0d samples over several window and edge settings,", samples_sent);
      $display("checked %0d median responses, %0d errors.", medians_seen, errors);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Hard limit on the run.
   initial begin
      #8000000;
      $display("simulation failed");
      $finish;
   end

endmodule

/* files.f */
hdl/rmf_pkg.sv
hdl/rmf_sort_cell.sv
hdl/row_median_filter.sv
verif/row_median_filter_tb.sv
